/* design/mt64_pkg.sv */
// ----------------------------------------------------------------------------
// mt64_pkg
// Types and constants for the 64-bit Mersenne Twister generator unit.
// ----------------------------------------------------------------------------
package mt64_pkg;

	localparam int StateWords   = 312;
	localparam int MiddleOffset = 156;
	localparam int MaxKeys      = 8;
	localparam int IdxW         = 9;
	localparam int KeyIdxW      = 3;
	localparam int KeyCntW      = 4;

	localparam logic [63:0] TwistMatrix = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] UpperMask   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] LowerMask   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] InitMult    = 64'd6364136223846793005;
	localparam logic [63:0] Mix1Mult    = 64'd3935559000370003845;
	localparam logic [63:0] Mix2Mult    = 64'd2862933555777941757;
	localparam logic [63:0] WarmSeed    = 64'd19650218;

	localparam logic [1:0] OpDraw = 2'd0;
	localparam logic [1:0] OpSeed = 2'd1;
	localparam logic [1:0] OpKey  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] value_word;
		logic        last_key;
	} in_item_t;

	typedef struct packed {
		logic [63:0] random_word;
		logic [52:0] random_fraction;
		logic        not_seeded;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LIN_MUL,   // multiply previous word
		ST_LIN_WR,
		ST_MIX_RD,    // read word i
		ST_MIX_MUL,
		ST_MIX_WR,
		ST_WRAP_RD,   // load prev from word 0
		ST_WRAP_WR,
		ST_FIX0,
		ST_GEN_RD0,   // regeneration: read cur
		ST_GEN_RD1,   // read next
		ST_GEN_RD2,   // read far
		ST_GEN_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT,
		ST_OUT
	} fsm_t;

	function automatic logic [63:0] temper(input logic [63:0] v);
		logic [63:0] x;
		x = v;
		x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
		x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
		x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
		x = x ^ (x >> 43);
		return x;
	endfunction

endpackage

/* design/mt64_mul64.sv */
// ----------------------------------------------------------------------------
// mt64_mul64
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// ----------------------------------------------------------------------------
module mt64_mul64 import mt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [63:0] a_q, b_q;
	logic [1:0]  step_q;
	logic [63:0] ll_q;
	logic [31:0] lh_q, hl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
		end else if (start) begin
			step_q <= 2'd1;
		end else if (step_q != 2'd0) begin
			step_q <= (step_q == 2'd3) ? 2'd0 : step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (step_q == 2'd1) ll_q <= a_q[31:0] * b_q[31:0];
		if (step_q == 2'd2) begin
			lh_q <= 32'(a_q[31:0] * b_q[63:32]);
			hl_q <= 32'(a_q[63:32] * b_q[31:0]);
		end
		if (step_q == 2'd3) p <= ll_q + {lh_q + hl_q, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= (step_q == 2'd3);
	end
endmodule

/* design/mt19937_64_generator_unit.sv */
// ----------------------------------------------------------------------------
// mt19937_64_generator_unit
// 64-bit Mersenne Twister with single-seed and key-array seeding.
// ----------------------------------------------------------------------------
// Channels: in (opcode, value_word, last_key) and out (random_word,
// random_fraction, not_seeded), both valid/ready. Only a draw (opcode 0)
// gives an output transfer; seeds and key words give none.
// The 312-word state lives in one memory with a registered read port and a
// separate write port. A draw with words left reads its word in ST_DRAW_RD,
// then tempers it in ST_DRAW_OUT, which registers the result and out_valid.
// When the state is used up it is regenerated first: for each word the
// current, next and far words are read and the twisted word is written back.
// A single-value seed fills each word with one 64-bit multiply. Array
// seeding runs the warm-up fill plus two mixing passes. One item is in work
// at a time; in_ready is high only when idle.
// After reset the block is unseeded; a draw then returns zeros with
// not_seeded set in the cycle after its transfer. A stalled receiver holds the
// result in the output register and the block accepts nothing until it is
// taken.
// ----------------------------------------------------------------------------
module mt19937_64_generator_unit import mt64_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic [63:0] mem [StateWords];
	logic [63:0] rd_q;
	logic [IdxW-1:0] rd_addr, wr_addr;
	logic [63:0] wr_data;
	logic rd_en, wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	logic [63:0] keys [MaxKeys];
	logic [KeyCntW-1:0] key_count_q;
	logic seeded_q;
	logic [IdxW-1:0] pos_q;

	fsm_t state_q, state_d;
	logic [IdxW-1:0] n_q, n_d;        // index i / n
	logic [KeyIdxW-1:0] j_q, j_d;
	logic [KeyCntW-1:0] len_q, len_d;
	logic [IdxW:0] k_q, k_d;          // remaining count
	logic mix2_q, mix2_d;
	logic array_q, array_d;           // linear fill is part of array seeding
	logic [63:0] prev_q, prev_d;      // previous word kept in a register
	logic [63:0] cur_q, cur_d, nxt_q, nxt_d;
	out_item_t out_q, out_d;
	logic out_valid_q, out_valid_d;
	logic [IdxW-1:0] pos_d;
	logic seeded_d;
	logic [KeyCntW-1:0] key_count_d;
	logic key_wr;

	logic mul_start, mul_done;
	logic [63:0] mul_a, mul_b, mul_p;

	mt64_mul64 u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	logic in_xfer;
	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	function automatic logic [IdxW-1:0] wrap_idx(input logic [IdxW:0] v);
		return (v >= (IdxW+1)'(StateWords)) ? IdxW'(v - (IdxW+1)'(StateWords)) : v[IdxW-1:0];
	endfunction

	function automatic logic [63:0] twist(input logic [63:0] c, input logic [63:0] nx,
		input logic [63:0] fr);
		logic [63:0] x;
		x = (c & UpperMask) | (nx & LowerMask);
		return fr ^ (x >> 1) ^ (x[0] ? TwistMatrix : 64'd0);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			seeded_q    <= 1'b0;
			pos_q       <= IdxW'(StateWords + 1);
			key_count_q <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			seeded_q    <= seeded_d;
			pos_q       <= pos_d;
			key_count_q <= key_count_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d; j_q <= j_d; len_q <= len_d; k_q <= k_d;
		mix2_q <= mix2_d; array_q <= array_d;
		prev_q <= prev_d; cur_q <= cur_d; nxt_q <= nxt_d;
		out_q <= out_d;
		if (key_wr) keys[key_count_q[KeyIdxW-1:0]] <= in_data.value_word;
	end

	always_comb begin
		logic [63:0] pm;
		logic [IdxW-1:0] nxi, fri;
		state_d = state_q; n_d = n_q; j_d = j_q; len_d = len_q; k_d = k_q;
		mix2_d = mix2_q; array_d = array_q;
		prev_d = prev_q; cur_d = cur_q; nxt_d = nxt_q;
		out_d = out_q; out_valid_d = out_valid_q;
		pos_d = pos_q; seeded_d = seeded_q; key_count_d = key_count_q;
		key_wr = 1'b0;
		rd_en = 1'b0; rd_addr = n_q; wr_en = 1'b0; wr_addr = n_q; wr_data = '0;
		mul_start = 1'b0; mul_a = '0; mul_b = '0;
		pm = prev_q ^ (prev_q >> 62);
		nxi = wrap_idx({1'b0, n_q} + 1'b1);
		fri = wrap_idx({1'b0, n_q} + (IdxW+1)'(MiddleOffset));

		if (out_valid_q && out_ready) out_valid_d = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (in_data.opcode)
						OpDraw: begin
							if (!seeded_q) begin
								out_d = '{64'd0, 53'd0, 1'b1};
								out_valid_d = 1'b1;
							end else if (pos_q >= IdxW'(StateWords)) begin
								n_d = '0;
								state_d = ST_GEN_RD0;
							end else begin
								state_d = ST_DRAW_RD;
							end
						end
						OpSeed: begin
							wr_en = 1'b1; wr_addr = '0; wr_data = in_data.value_word;
							prev_d = in_data.value_word; n_d = IdxW'(1);
							array_d = 1'b0; key_count_d = '0; seeded_d = 1'b1;
							state_d = ST_LIN_MUL;
						end
						OpKey: begin
							logic [KeyCntW-1:0] kc;
							kc = key_count_q;
							if (key_count_q < KeyCntW'(MaxKeys)) begin
								key_wr = 1'b1;
								kc = key_count_q + 1'b1;
							end
							key_count_d = kc;
							if (in_data.last_key) begin
								len_d = (kc == '0) ? KeyCntW'(1) : kc;
								wr_en = 1'b1; wr_addr = '0; wr_data = WarmSeed;
								prev_d = WarmSeed; n_d = IdxW'(1);
								array_d = 1'b1; key_count_d = '0; seeded_d = 1'b1;
								state_d = ST_LIN_MUL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LIN_MUL: begin
				mul_start = 1'b1; mul_a = pm; mul_b = InitMult;
				state_d = ST_LIN_WR;
			end
			ST_LIN_WR: begin
				if (mul_done) begin
					wr_en = 1'b1;
					wr_data = mul_p + 64'(n_q);
					prev_d = wr_data;
					if (n_q == IdxW'(StateWords - 1)) begin
						pos_d = IdxW'(StateWords);
						if (array_q) begin
							// mixing starts at i=1, prev = word 0
							n_d = IdxW'(1); j_d = '0; mix2_d = 1'b0;
							k_d = (IdxW+1)'(StateWords);
							rd_en = 1'b0;
							state_d = ST_WRAP_RD;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						n_d = n_q + 1'b1;
						state_d = ST_LIN_MUL;
					end
				end
			end
			ST_WRAP_RD: begin
				// load prev = word (n-1); entered with n=1 so read word 0
				rd_en = 1'b1; rd_addr = n_q - 1'b1;
				state_d = ST_WRAP_WR;
			end
			ST_WRAP_WR: begin
				prev_d = rd_q;
				state_d = ST_MIX_RD;
			end
			ST_MIX_RD: begin
				rd_en = 1'b1; rd_addr = n_q;
				mul_start = 1'b1; mul_a = pm; mul_b = mix2_q ? Mix2Mult : Mix1Mult;
				state_d = ST_MIX_MUL;
			end
			ST_MIX_MUL: begin
				cur_d = rd_q;
				state_d = ST_MIX_WR;
			end
			ST_MIX_WR: begin
				if (mul_done) begin
					logic [63:0] v;
					if (mix2_q) v = (cur_q ^ mul_p) - 64'(n_q);
					else v = (cur_q ^ mul_p) + keys[j_q] + 64'(j_q);
					wr_en = 1'b1; wr_data = v; prev_d = v;
					if (!mix2_q) j_d = ({1'b0, j_q} + 1'b1 >= len_q) ? '0 : j_q + 1'b1;
					k_d = k_q - 1'b1;
					if (n_q == IdxW'(StateWords - 1)) begin
						n_d = IdxW'(1);
						state_d = ST_FIX0; // write word 0 = last word
					end else begin
						n_d = n_q + 1'b1;
						state_d = ST_MIX_RD;
					end
					if (k_q == (IdxW+1)'(1)) begin
						if (!mix2_q) begin
							mix2_d = 1'b1; k_d = (IdxW+1)'(StateWords - 1);
						end else if (n_q != IdxW'(StateWords - 1)) begin
							state_d = ST_FIX0; k_d = '0;
						end else begin
							k_d = '0;
						end
					end
				end
			end
			ST_FIX0: begin
				wr_en = 1'b1; wr_addr = '0;
				if (k_q == '0) begin
					wr_data = 64'h8000_0000_0000_0000;
					state_d = ST_IDLE;
				end else begin
					wr_data = prev_q;  // copy of last word; prev stays for i=1
					state_d = ST_MIX_RD;
				end
			end
			ST_GEN_RD0: begin
				rd_en = 1'b1; rd_addr = n_q;
				state_d = ST_GEN_RD1;
			end
			ST_GEN_RD1: begin
				cur_d = rd_q;
				rd_en = 1'b1; rd_addr = nxi;
				state_d = ST_GEN_RD2;
			end
			ST_GEN_RD2: begin
				// for the last word this is the already regenerated word 0
				nxt_d = rd_q;
				rd_en = 1'b1; rd_addr = fri;
				state_d = ST_GEN_WR;
			end
			ST_GEN_WR: begin
				// far word already updated when fri < n, which the memory holds
				wr_en = 1'b1;
				wr_data = twist(cur_q, nxt_q, rd_q);
				if (n_q == IdxW'(StateWords - 1)) begin
					pos_d = '0;
					state_d = ST_DRAW_RD;
				end else begin
					n_d = n_q + 1'b1;
					state_d = ST_GEN_RD0;
				end
			end
			ST_DRAW_RD: begin
				rd_en = 1'b1; rd_addr = pos_q;
				state_d = ST_DRAW_OUT;
			end
			ST_DRAW_OUT: begin
				logic [63:0] t;
				t = temper(rd_q);
				out_d = '{t, t[63:11], 1'b0};
				out_valid_d = 1'b1;
				pos_d = pos_q + 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
